// ----- sv/sign_magnitude_varint_codec_macros.svh -----
// assertion macros for the sign-magnitude varint codec
// expects a clock i_clk and an active-low reset i_rst_n in the including scope
`ifndef SIGN_MAGNITUDE_VARINT_CODEC_MACROS_SVH
`define SIGN_MAGNITUDE_VARINT_CODEC_MACROS_SVH

// same-cycle implication, off during reset
`define SMV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define SMV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/smv_pkg.sv -----
// shared types and constants for the sign-magnitude varint codec
// no dependencies
package smv_pkg;

    localparam int MAX_GROUPS_DEF = 5;
    localparam int GROUP_BITS     = 7;
    localparam int WORD_W         = 32;
    localparam int BYTE_W         = 8;
    localparam int KIND_W         = 2;

    localparam logic [WORD_W-1:0] MOST_NEG = 32'h8000_0000;
    localparam logic [WORD_W-1:0] MAX_MAG  = 32'h7FFF_FFFF;

    typedef enum logic [KIND_W-1:0] {
        KIND_BYTE  = 2'd0,
        KIND_VALUE = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef enum logic [0:0] {
        FUNC_ENCODE = 1'b0,
        FUNC_DECODE = 1'b1
    } t_func;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_ENC  = 1'b1
    } t_state;

    typedef struct packed {
        logic accept;  // input transfer this cycle
        logic emit;    // send next encoded group from the word register
    } t_cmd;

    typedef struct packed {
        logic out_free;   // output register can load this cycle
        logic word_more;  // word register still holds more than one group
        logic new_more;   // incoming encode item needs more than one byte
    } t_sts;

endpackage

// ----- sv/sign_magnitude_varint_codec.sv -----
// Sign-magnitude varint codec. tuser selects encode (0) or decode (1). Encode turns a
// signed 32-bit value into (magnitude << 1) | sign and sends it as little-endian 7-bit
// groups, bit 7 set on all but the final byte: 1 to 5 output transfers, one per cycle
// while the output register is free; the next item is taken once the last byte enters
// the output register. Decode takes one byte per cycle when the output register is free
// and yields a value or an error transfer only on the closing byte;
// a sixth group, payload bits beyond bit 31, or a continuation byte with tlast set give
// an error and clear the partial word. Encoding leaves a partial decode untouched.
// Throughput is set by the single output register, which moves one result per cycle when not stalled.
// depends on smv_pkg, smv_ctrl, smv_datapath, sign_magnitude_varint_codec_macros.svh
`include "sign_magnitude_varint_codec_macros.svh"

module sign_magnitude_varint_codec #(
    parameter int MAX_GROUPS = smv_pkg::MAX_GROUPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // value_in [31:0], byte_in [39:32]
    input  logic [0:0]  s_axis_tuser,   // func [0]
    input  logic        s_axis_tlast,   // buffer_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // byte_out [7:0], value_out [39:8]
    output logic [1:0]  m_axis_tuser,   // kind [1:0]
    output logic        m_axis_tlast    // last
);

    smv_pkg::t_cmd  w_cmd;
    smv_pkg::t_sts  w_sts;
    smv_pkg::t_kind w_kind;
    logic [smv_pkg::BYTE_W-1:0] w_byte;
    logic [smv_pkg::WORD_W-1:0] w_value;

    smv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_sts      (w_sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    smv_datapath #(
        .MAX_GROUPS (MAX_GROUPS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_func       (s_axis_tuser[0]),
        .i_value      (s_axis_tdata[31:0]),
        .i_byte       (s_axis_tdata[39:32]),
        .i_buffer_end (s_axis_tlast),
        .i_out_ready  (m_axis_tready),
        .o_sts        (w_sts),
        .o_out_valid  (m_axis_tvalid),
        .o_kind       (w_kind),
        .o_byte       (w_byte),
        .o_value      (w_value),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {w_value, w_byte};
    assign m_axis_tuser = w_kind;

    // a held result blocks the input side
    `SMV_ASSERT_NOW(a_stall_blocks_input, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input ready while output stalled")
    // encoded bytes carry the continuation flag exactly when not final
    `SMV_ASSERT_NOW(a_cont_flag, m_axis_tvalid && (w_kind == smv_pkg::KIND_BYTE), m_axis_tlast == !w_byte[7], "continuation flag disagrees with last")
    // value and error results always close their item
    `SMV_ASSERT_NOW(a_single_result, m_axis_tvalid && (w_kind != smv_pkg::KIND_BYTE), m_axis_tlast, "decode result without last")
    // a non-final encoded byte is followed by more output of the same item
    `SMV_ASSERT_NEXT(a_enc_continues, m_axis_tvalid && m_axis_tready && (w_kind == smv_pkg::KIND_BYTE) && !m_axis_tlast, m_axis_tvalid && (w_kind == smv_pkg::KIND_BYTE), "encode run broken")

endmodule

// ----- sv/smv_ctrl.sv -----
// controller for the sign-magnitude varint codec: idle / encode-drain sequencing
// depends on smv_pkg
module smv_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  smv_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output smv_pkg::t_cmd o_cmd
);

    smv_pkg::t_state r_state;
    smv_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smv_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            smv_pkg::ST_IDLE: begin
                if (i_in_valid && i_sts.out_free && i_sts.new_more) begin
                    n_state = smv_pkg::ST_ENC;
                end
            end
            smv_pkg::ST_ENC: begin
                if (i_sts.out_free && !i_sts.word_more) begin
                    n_state = smv_pkg::ST_IDLE;
                end
            end
            default: n_state = smv_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        case (r_state)
            smv_pkg::ST_IDLE: begin
                o_in_ready   = i_sts.out_free;
                o_cmd.accept = i_in_valid && i_sts.out_free;
            end
            smv_pkg::ST_ENC: begin
                o_cmd.emit = i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- sv/smv_datapath.sv -----
// datapath for the sign-magnitude varint codec: code word register,
// decode accumulator and group count, output register
// depends on smv_pkg
module smv_datapath #(
    parameter int MAX_GROUPS = smv_pkg::MAX_GROUPS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  smv_pkg::t_cmd                i_cmd,
    input  logic                         i_func,
    input  logic [smv_pkg::WORD_W-1:0]   i_value,
    input  logic [smv_pkg::BYTE_W-1:0]   i_byte,
    input  logic                         i_buffer_end,
    input  logic                         i_out_ready,
    output smv_pkg::t_sts                o_sts,
    output logic                         o_out_valid,
    output smv_pkg::t_kind               o_kind,
    output logic [smv_pkg::BYTE_W-1:0]   o_byte,
    output logic [smv_pkg::WORD_W-1:0]   o_value,
    output logic                         o_last
);

    localparam int WW     = smv_pkg::WORD_W;
    localparam int GB     = smv_pkg::GROUP_BITS;
    localparam int CNT_W  = $clog2(MAX_GROUPS + 1);
    localparam int SH_W   = $clog2(GB * MAX_GROUPS + 1);
    localparam int WIDE_W = WW + GB * (MAX_GROUPS + 1);

    logic [WW-1:0]    r_acc,   n_acc;
    logic [CNT_W-1:0] r_count, n_count;
    logic [WW-1:0]    r_word,  n_word;
    logic             r_out_valid, n_out_valid;
    smv_pkg::t_kind   r_kind,  n_kind;
    logic [smv_pkg::BYTE_W-1:0] r_byte, n_byte;
    logic [WW-1:0]    r_value, n_value;
    logic             r_last,  n_last;

    logic [WW-1:0]     w_mag;
    logic [WW-1:0]     w_new_word;
    logic [WW-1:0]     w_src_word;
    logic              w_src_more;
    logic [SH_W-1:0]   w_shift;
    logic [WIDE_W-1:0] w_wide;
    logic              w_over;
    logic              w_too_many;
    logic [WW-1:0]     w_acc_or;
    logic [WW-1:0]     w_dec_mag;
    logic              w_out_free;
    logic              w_enc_load;
    logic              w_dec;

    // sign-magnitude code word of the incoming value; most negative saturates
    always_comb begin
        w_mag = WW'(0) - i_value;
        if (i_value == smv_pkg::MOST_NEG) begin
            w_mag = smv_pkg::MAX_MAG;
        end
        if (i_value[WW-1]) begin
            w_new_word = {w_mag[WW-2:0], 1'b1};
        end else begin
            w_new_word = {i_value[WW-2:0], 1'b0};
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_enc_load = i_cmd.accept && (i_func == smv_pkg::FUNC_ENCODE);
    assign w_dec      = i_cmd.accept && (i_func == smv_pkg::FUNC_DECODE);

    // group source: fresh word on accept, word register while draining
    assign w_src_word = w_enc_load ? w_new_word : r_word;
    assign w_src_more = |w_src_word[WW-1:GB];

    // decode group placement
    assign w_shift    = SH_W'(r_count) * SH_W'(GB);
    assign w_wide     = {{(WIDE_W-GB){1'b0}}, i_byte[GB-1:0]} << w_shift;
    assign w_over     = |w_wide[WIDE_W-1:WW];
    assign w_too_many = r_count >= CNT_W'(MAX_GROUPS);
    assign w_acc_or   = r_acc | w_wide[WW-1:0];
    assign w_dec_mag  = {1'b0, w_acc_or[WW-1:1]};

    always_comb begin
        n_acc       = r_acc;
        n_count     = r_count;
        n_word      = r_word;
        n_kind      = r_kind;
        n_byte      = r_byte;
        n_value     = r_value;
        n_last      = r_last;
        n_out_valid = r_out_valid && !i_out_ready;

        if (w_enc_load || i_cmd.emit) begin
            n_out_valid = 1'b1;
            n_kind      = smv_pkg::KIND_BYTE;
            n_byte      = {w_src_more, w_src_word[GB-1:0]};
            n_value     = '0;
            n_last      = !w_src_more;
            n_word      = w_src_word >> GB;
        end

        if (w_dec) begin
            if (w_too_many || w_over || (i_byte[GB] && i_buffer_end)) begin
                n_acc       = '0;
                n_count     = '0;
                n_out_valid = 1'b1;
                n_kind      = smv_pkg::KIND_ERROR;
                n_byte      = '0;
                n_value     = '0;
                n_last      = 1'b1;
            end else if (i_byte[GB]) begin
                // continuation: keep collecting, no result
                n_acc   = w_acc_or;
                n_count = r_count + CNT_W'(1);
            end else begin
                n_acc       = '0;
                n_count     = '0;
                n_out_valid = 1'b1;
                n_kind      = smv_pkg::KIND_VALUE;
                n_byte      = '0;
                n_value     = w_acc_or[0] ? (WW'(0) - w_dec_mag) : w_dec_mag;
                n_last      = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word  <= n_word;
        r_kind  <= n_kind;
        r_byte  <= n_byte;
        r_value <= n_value;
        r_last  <= n_last;
    end

    assign o_sts.out_free  = w_out_free;
    assign o_sts.word_more = |r_word[WW-1:GB];
    assign o_sts.new_more  = (i_func == smv_pkg::FUNC_ENCODE) && (|w_new_word[WW-1:GB]);

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_byte      = r_byte;
    assign o_value     = r_value;
    assign o_last      = r_last;

endmodule
